/* rtl/assert_macros.svh */
// Assertion helpers for the matcher RTL.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that must hold at every clock edge.
`define WSEM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define WSEM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/wsem_pkg.sv */
`default_nettype none
package wsem_pkg;

    localparam int REF_DEPTH    = 1024;
    localparam int WINDOW       = 32;
    localparam int TIME_BITS    = 32;
    localparam int FEATURE_BITS = 16;

    localparam int REF_AW    = $clog2(REF_DEPTH);
    localparam int COUNT_BITS = REF_AW + 1;
    localparam int WIN_AW    = $clog2(WINDOW);
    localparam int FILL_BITS = $clog2(WINDOW + 1);

    localparam int OP_BITS   = 2;
    localparam int WL_BITS   = 6;
    localparam int TH_BITS   = 15;
    localparam int SQ_BITS   = 35;
    localparam int SUM_BITS  = 40;
    localparam int LIM_BITS  = 35;
    localparam int MAG_BITS  = FEATURE_BITS + 1;

    localparam int MUL_A_BITS = 2 * TH_BITS;
    localparam int MUL_B_BITS = MAG_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [WL_BITS-1:0] WL_RESET = WL_BITS'(32);
    localparam logic [TH_BITS-1:0] TH_RESET = TH_BITS'(100);

    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TEST  = 2'd2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_THRESHOLD     = 1'b1
    } t_cfg_reg;

endpackage
`default_nettype wire

/* rtl/wsem_ifs.sv */
`default_nettype none
interface wsem_in_if import wsem_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic [OP_BITS-1:0]             operation;
    logic [TIME_BITS-1:0]           timestamp;
    logic signed [FEATURE_BITS-1:0] feature_value;

    modport source (output valid, output operation, output timestamp,
                    output feature_value, input ready);
    modport sink   (input valid, input operation, input timestamp,
                    input feature_value, output ready);
endinterface

interface wsem_out_if import wsem_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] test_time;
    logic [TIME_BITS-1:0] ref_time;
    logic [SQ_BITS-1:0]   squared_error;
    logic [SUM_BITS-1:0]  window_sum;
    logic [LIM_BITS-1:0]  limit_value;
    logic                 is_summary;
    logic                 last;

    modport source (output valid, output test_time, output ref_time,
                    output squared_error, output window_sum, output limit_value,
                    output is_summary, output last, input ready);
    modport sink   (input valid, input test_time, input ref_time,
                    input squared_error, input window_sum, input limit_value,
                    input is_summary, input last, output ready);
endinterface

interface wsem_cfg_if import wsem_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_cfg_reg                 reg_index;
    logic [CFG_DATA_BITS-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

/* rtl/windowed_squared_error_matcher.sv */
// Channel  Dir  Beat contents
// i_in     in   operation, timestamp, feature_value
// o_out    out  test_time, ref_time, squared_error, window_sum, limit_value,
//               is_summary, last
// i_cfg    in   reg_index (window_length, threshold), wdata
//
// Clear and load beats are handled in idle; i_in.ready stays high in idle.
// A test beat holds i_in.ready low from its accept through S_PCMP, S_SQ, S_TH,
// S_LIM, S_DROP and S_CHK; S_PCMP repeats per pointer step, S_DROP per drop.
// The shared multiplier runs three times per test (square, thr^2, *length).
// An alarm then emits each window entry in S_EMIT and the summary beat in S_SUM,
// each waiting for a free output register while o_out.ready is low.
// i_rst_n is synchronous; the RAMs are not cleared. i_cfg is always ready.
`default_nettype none
`include "assert_macros.svh"
module windowed_squared_error_matcher import wsem_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wsem_in_if.sink    i_in,
    wsem_out_if.source o_out,
    wsem_cfg_if.sink   i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE, S_PCMP, S_SQ, S_TH, S_LIM, S_DROP, S_CHK, S_EMIT, S_SUM
    } t_state;

    // Add an offset to a ring position, wrapping once at the window depth.
    function automatic logic [WIN_AW-1:0] ring_add(input logic [WIN_AW-1:0] a,
                                                  input logic [WIN_AW-1:0] b);
        logic [WIN_AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (WIN_AW+1)'(WINDOW)) begin
            s = s - (WIN_AW+1)'(WINDOW);
        end
        return s[WIN_AW-1:0];
    endfunction

    // Reference table and window ring, registered read ports.
    logic [TIME_BITS-1:0]    ref_times_mem    [REF_DEPTH];
    logic [FEATURE_BITS-1:0] ref_features_mem [REF_DEPTH];
    logic [SQ_BITS-1:0]      win_err_mem      [WINDOW];
    logic [TIME_BITS-1:0]    win_tt_mem       [WINDOW];
    logic [TIME_BITS-1:0]    win_rt_mem       [WINDOW];

    logic [TIME_BITS-1:0]    r_rt_q;
    logic [FEATURE_BITS-1:0] r_rf_q;
    logic [SQ_BITS-1:0]      r_we_q;
    logic [TIME_BITS-1:0]    r_wtt_q;
    logic [TIME_BITS-1:0]    r_wrt_q;

    // Control state.
    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [REF_AW-1:0]     r_ptr, n_ptr;
    logic [WIN_AW-1:0]     r_head, n_head;
    logic [FILL_BITS-1:0]  r_fill, n_fill;
    logic [WIN_AW-1:0]     r_cnt, n_cnt;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [WL_BITS-1:0]    r_wl, n_wl;
    logic [TH_BITS-1:0]    r_th, n_th;
    logic                  r_ovalid, n_ovalid;

    // Per-item working registers.
    logic [TIME_BITS-1:0]    r_ts, n_ts;
    logic [FEATURE_BITS-1:0] r_feat, n_feat;
    logic [MAG_BITS-1:0]     r_mag, n_mag;
    logic [SQ_BITS-1:0]      r_sq, n_sq;
    logic [PROD_BITS-1:0]    r_prod, n_prod;

    // Output register.
    logic [TIME_BITS-1:0] r_o_tt, n_o_tt;
    logic [TIME_BITS-1:0] r_o_rt, n_o_rt;
    logic [SQ_BITS-1:0]   r_o_se, n_o_se;
    logic [SUM_BITS-1:0]  r_o_ws, n_o_ws;
    logic [LIM_BITS-1:0]  r_o_lv, n_o_lv;
    logic                 r_o_summ, n_o_summ;

    logic                    accept;
    logic                    slot_free;
    logic [FILL_BITS-1:0]    wl_eff;
    logic [MUL_A_BITS-1:0]   mul_a;
    logic [MUL_B_BITS-1:0]   mul_b;
    logic [PROD_BITS-1:0]    mul_p;
    logic                    mul_en;
    logic [SUM_BITS-1:0]     add_op;
    logic                    add_sub;
    logic [SUM_BITS-1:0]     add_res;
    logic [MAG_BITS-1:0]     diff;
    logic                    ref_we;
    logic                    win_we;
    logic [WIN_AW-1:0]       win_waddr;
    logic [WIN_AW-1:0]       win_raddr;
    logic [COUNT_BITS-1:0]   ptr_next;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign slot_free   = !r_ovalid || o_out.ready;

    // Clamp the window length into 1..WINDOW.
    always_comb begin
        if (r_wl == '0) begin
            wl_eff = FILL_BITS'(1);
        end else if (FILL_BITS'(r_wl) > FILL_BITS'(WINDOW)) begin
            wl_eff = FILL_BITS'(WINDOW);
        end else begin
            wl_eff = FILL_BITS'(r_wl);
        end
    end

    // The one multiplier, shared by the square and the two limit products.
    always_comb begin
        mul_a  = MUL_A_BITS'(r_mag);
        mul_b  = r_mag;
        mul_en = 1'b0;
        case (r_state)
            S_SQ: begin
                mul_en = 1'b1;
            end
            S_TH: begin
                mul_a  = MUL_A_BITS'(r_th);
                mul_b  = MUL_B_BITS'(r_th);
                mul_en = 1'b1;
            end
            S_LIM: begin
                mul_a  = r_prod[MUL_A_BITS-1:0];
                mul_b  = MUL_B_BITS'(wl_eff);
                mul_en = 1'b1;
            end
            default: begin
            end
        endcase
    end
    assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    // The one accumulator: subtract a dropped error or add the new square.
    assign add_sub = (r_fill >= wl_eff);
    assign add_op  = add_sub ? ~SUM_BITS'(r_we_q) : SUM_BITS'(r_sq);
    assign add_res = r_sum + add_op + SUM_BITS'(add_sub);

    assign diff     = MAG_BITS'($signed({r_rf_q[FEATURE_BITS-1], r_rf_q})
                                - $signed({r_feat[FEATURE_BITS-1], r_feat}));
    assign ptr_next = COUNT_BITS'(r_ptr) + COUNT_BITS'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_head   = r_head;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_wl     = r_wl;
        n_th     = r_th;
        n_ts     = r_ts;
        n_feat   = r_feat;
        n_mag    = r_mag;
        n_sq     = r_sq;
        n_prod   = mul_en ? mul_p : r_prod;
        n_o_tt   = r_o_tt;
        n_o_rt   = r_o_rt;
        n_o_se   = r_o_se;
        n_o_ws   = r_o_ws;
        n_o_lv   = r_o_lv;
        n_o_summ = r_o_summ;
        n_ovalid = o_out.ready ? 1'b0 : r_ovalid;
        ref_we   = 1'b0;
        win_we   = 1'b0;
        win_waddr = ring_add(r_head, r_fill[WIN_AW-1:0]);

        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_WINDOW_LENGTH: n_wl = i_cfg.wdata[WL_BITS-1:0];
                CFG_THRESHOLD:     n_th = i_cfg.wdata[TH_BITS-1:0];
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ts   = i_in.timestamp;
                    n_feat = i_in.feature_value;
                    case (i_in.operation)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_ptr   = '0;
                            n_head  = '0;
                            n_fill  = '0;
                            n_sum   = '0;
                        end
                        OP_LOAD: begin
                            if (r_count < COUNT_BITS'(REF_DEPTH)) begin
                                ref_we  = 1'b1;
                                n_count = r_count + COUNT_BITS'(1);
                            end
                        end
                        OP_TEST: begin
                            if (r_count != '0) begin
                                n_state = S_PCMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Step the reference pointer while the test time is later, up to the last entry.
            S_PCMP: begin
                if (ptr_next < r_count && r_ts > r_rt_q) begin
                    n_ptr = r_ptr + REF_AW'(1);
                end else begin
                    n_mag   = diff[MAG_BITS-1] ? (~diff + MAG_BITS'(1)) : diff;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_TH;
            end
            S_TH: begin
                n_sq    = r_prod[SQ_BITS-1:0];
                n_state = S_LIM;
            end
            S_LIM: begin
                n_state = S_DROP;
            end
            // Drop the oldest entries until the new one fits, then append it.
            S_DROP: begin
                n_sum = add_res;
                if (add_sub) begin
                    n_head = ring_add(r_head, WIN_AW'(1));
                    n_fill = r_fill - FILL_BITS'(1);
                end else begin
                    win_we  = 1'b1;
                    n_fill  = r_fill + FILL_BITS'(1);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_cnt = '0;
                if (r_sum > SUM_BITS'(r_prod[LIM_BITS-1:0])) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // Emit window entries oldest first, one per free output slot.
            S_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_o_tt   = r_wtt_q;
                    n_o_rt   = r_wrt_q;
                    n_o_se   = r_we_q;
                    n_o_ws   = '0;
                    n_o_lv   = '0;
                    n_o_summ = 1'b0;
                    if (FILL_BITS'(r_cnt) == r_fill - FILL_BITS'(1)) begin
                        n_state = S_SUM;
                    end else begin
                        n_cnt = r_cnt + WIN_AW'(1);
                    end
                end
            end
            S_SUM: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_o_tt   = '0;
                    n_o_rt   = '0;
                    n_o_se   = '0;
                    n_o_ws   = r_sum;
                    n_o_lv   = r_prod[LIM_BITS-1:0];
                    n_o_summ = 1'b1;
                    n_state  = S_IDLE;
                end
            end
        endcase
    end

    // Window read address follows the next head or emission position, so the
    // registered read data always matches the current position.
    assign win_raddr = (n_state == S_EMIT) ? ring_add(n_head, n_cnt) : n_head;

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            ref_times_mem[r_count[REF_AW-1:0]]    <= i_in.timestamp;
            ref_features_mem[r_count[REF_AW-1:0]] <= i_in.feature_value;
        end
        r_rt_q <= ref_times_mem[n_ptr];
        r_rf_q <= ref_features_mem[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            win_err_mem[win_waddr] <= r_sq;
            win_tt_mem[win_waddr]  <= r_ts;
            win_rt_mem[win_waddr]  <= r_rt_q;
        end
        r_we_q  <= win_err_mem[win_raddr];
        r_wtt_q <= win_tt_mem[win_raddr];
        r_wrt_q <= win_rt_mem[win_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ptr    <= '0;
            r_head   <= '0;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_wl     <= WL_RESET;
            r_th     <= TH_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_wl     <= n_wl;
            r_th     <= n_th;
            r_ovalid <= n_ovalid;
            r_ts     <= n_ts;
            r_feat   <= n_feat;
            r_mag    <= n_mag;
            r_sq     <= n_sq;
            r_prod   <= n_prod;
            r_o_tt   <= n_o_tt;
            r_o_rt   <= n_o_rt;
            r_o_se   <= n_o_se;
            r_o_ws   <= n_o_ws;
            r_o_lv   <= n_o_lv;
            r_o_summ <= n_o_summ;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.test_time     = r_o_tt;
    assign o_out.ref_time      = r_o_rt;
    assign o_out.squared_error = r_o_se;
    assign o_out.window_sum    = r_o_ws;
    assign o_out.limit_value   = r_o_lv;
    assign o_out.is_summary    = r_o_summ;
    assign o_out.last          = r_o_summ;

    `WSEM_ASSERT(a_fill_max, r_fill <= FILL_BITS'(WINDOW), "window fill beyond depth")
    `WSEM_ASSERT_IMPL(a_ptr_range, r_count != '0, COUNT_BITS'(r_ptr) < r_count, "ptr past table")
    `WSEM_ASSERT_IMPL(a_chk_fill, r_state == S_CHK, r_fill != '0 && r_fill <= wl_eff, "bad fill")
    `WSEM_ASSERT_IMPL(a_emit_cnt, r_state == S_EMIT, FILL_BITS'(r_cnt) < r_fill, "emit past fill")

endmodule
`default_nettype wire

/* tb/sv/tb_windowed_squared_error_matcher.sv */
`timescale 1ns / 1ps
module tb_windowed_squared_error_matcher;
    import wsem_pkg::*;

    // Operation code 3 has no meaning; the block must drop such beats.
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    localparam int FEATURE_MAX = 2 ** (FEATURE_BITS - 1) - 1;
    localparam int FEATURE_MIN = -(2 ** (FEATURE_BITS - 1));

    localparam int unsigned MAX_GAP          = 16;
    // Worst silent test: a pointer sweep over the whole table plus window drops.
    localparam int unsigned DRAIN_CYCLES     = 1200;
    localparam int unsigned LONG_HOLD_CYCLES = 600;

    typedef struct packed {
        logic [OP_BITS-1:0]             op;
        logic [TIME_BITS-1:0]           stamp;
        logic signed [FEATURE_BITS-1:0] feature;
    } sample_beat_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] test_time;
        logic [TIME_BITS-1:0] ref_time;
        logic [SQ_BITS-1:0]   squared_error;
        logic [SUM_BITS-1:0]  window_sum;
        logic [LIM_BITS-1:0]  limit_value;
        logic                 is_summary;
        logic                 last;
    } alarm_beat_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    wsem_in_if  in_if ();
    wsem_out_if out_if ();
    wsem_cfg_if cfg_if ();

    windowed_squared_error_matcher DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #10 i_clk = ~i_clk;

    sample_beat_t beats_to_send[$];
    alarm_beat_t  alarm_beats_due[$];
    int unsigned  mismatch_count = 0;

    // Shadow of the matcher: reference table, pointer, error ring, registers.
    logic [TIME_BITS-1:0]           table_stamps [REF_DEPTH];
    logic signed [FEATURE_BITS-1:0] table_features [REF_DEPTH];
    int unsigned                    loaded_refs = 0;
    int unsigned                    ref_cursor = 0;
    logic [SQ_BITS-1:0]             ring_errors [WINDOW];
    logic [TIME_BITS-1:0]           ring_test_stamps [WINDOW];
    logic [TIME_BITS-1:0]           ring_ref_stamps [WINDOW];
    int unsigned                    ring_head = 0;
    int unsigned                    ring_fill = 0;
    logic [SUM_BITS-1:0]            running_error = '0;
    logic [WL_BITS-1:0]             window_length_reg = WL_RESET;
    logic [TH_BITS-1:0]             threshold_reg = TH_RESET;

    // Idle pacing state of both sides, plus the one long receiver hold-off.
    int unsigned send_gap = 0;
    int unsigned send_burst = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_burst = 0;
    logic        hold_request = 1'b0;
    logic        hold_spent = 1'b0;
    int unsigned long_hold_left = 0;

    // Advance the shadow by one accepted input beat and queue the alarm beats it raises.
    function automatic void apply_input_beat(logic [OP_BITS-1:0] op,
                                             logic [TIME_BITS-1:0] stamp,
                                             logic signed [FEATURE_BITS-1:0] feature);
        int unsigned       span;
        int unsigned       slot;
        longint            diff;
        longint unsigned   sq;
        longint unsigned   th;
        longint unsigned   limit;
        alarm_beat_t       beat;
        case (op)
            OP_CLEAR: begin
                loaded_refs   = 0;
                ref_cursor    = 0;
                ring_head     = 0;
                ring_fill     = 0;
                running_error = '0;
            end
            OP_LOAD: begin
                // Drop loads once the table is full.
                if (loaded_refs < REF_DEPTH) begin
                    table_stamps[loaded_refs]   = stamp;
                    table_features[loaded_refs] = feature;
                    loaded_refs++;
                end
            end
            OP_TEST: begin
                // A test against an empty table leaves everything untouched.
                if (loaded_refs != 0) begin
                    while (ref_cursor + 1 < loaded_refs && stamp > table_stamps[ref_cursor])
                        ref_cursor++;
                    diff = longint'(table_features[ref_cursor]) - longint'(feature);
                    if (diff < 0)
                        diff = -diff;
                    sq = diff * diff;

                    // Zero length acts as one; anything past the ring saturates.
                    span = 32'(window_length_reg);
                    if (span == 0)
                        span = 1;
                    if (span > WINDOW)
                        span = WINDOW;

                    // Retire the oldest entries until the new one fits.
                    while (ring_fill >= span) begin
                        running_error = running_error - ring_errors[ring_head];
                        ring_head     = (ring_head + 1) % WINDOW;
                        ring_fill--;
                    end
                    slot                   = (ring_head + ring_fill) % WINDOW;
                    ring_errors[slot]      = SQ_BITS'(sq);
                    ring_test_stamps[slot] = stamp;
                    ring_ref_stamps[slot]  = table_stamps[ref_cursor];
                    ring_fill++;
                    running_error = running_error + SUM_BITS'(sq);

                    th    = 64'(threshold_reg);
                    limit = span * th * th;
                    if (running_error > limit) begin
                        for (int unsigned k = 0; k < ring_fill; k++) begin
                            slot               = (ring_head + k) % WINDOW;
                            beat               = '0;
                            beat.test_time     = ring_test_stamps[slot];
                            beat.ref_time      = ring_ref_stamps[slot];
                            beat.squared_error = ring_errors[slot];
                            alarm_beats_due    = {alarm_beats_due, beat};
                        end
                        beat             = '0;
                        beat.window_sum  = running_error;
                        beat.limit_value = LIM_BITS'(limit);
                        beat.is_summary  = 1'b1;
                        beat.last        = 1'b1;
                        alarm_beats_due  = {alarm_beats_due, beat};
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Mostly short waits, sometimes up to MAX_GAP, with bursts of back-to-back beats.
    function automatic int unsigned draw_gap(inout int unsigned burst);
        if (burst != 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 24);
            return 0;
        end
        case ($urandom_range(0, 3))
            0, 1: return 0;
            2: return $urandom_range(1, 3);
            default: return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < 50)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_alarm_beat();
        alarm_beat_t want;
        if (alarm_beats_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat test_time %0h summary %0b",
                                      out_if.test_time, out_if.is_summary));
        end else begin
            want = alarm_beats_due[0];
            alarm_beats_due.delete(0);
            compare_field("test_time", out_if.test_time, want.test_time);
            compare_field("ref_time", out_if.ref_time, want.ref_time);
            compare_field("squared_error", out_if.squared_error, want.squared_error);
            compare_field("window_sum", out_if.window_sum, want.window_sum);
            compare_field("limit_value", out_if.limit_value, want.limit_value);
            compare_field("is_summary", out_if.is_summary, want.is_summary);
            compare_field("last", out_if.last, want.last);
        end
    endtask

    // Driver: present queued beats, hold while stalled, idle between beats.
    always @(posedge i_clk) begin
        sample_beat_t next_beat;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready)
                apply_input_beat(in_if.operation, in_if.timestamp, in_if.feature_value);
            if (in_if.valid && !in_if.ready) begin
                // hold the beat until the block takes it
            end else if (send_gap != 0) begin
                in_if.valid <= 1'b0;
                send_gap--;
            end else if (beats_to_send.size() != 0) begin
                next_beat = beats_to_send[0];
                beats_to_send.delete(0);
                in_if.valid         <= 1'b1;
                in_if.operation     <= next_beat.op;
                in_if.timestamp     <= next_beat.stamp;
                in_if.feature_value <= next_beat.feature;
                send_gap = draw_gap(send_burst);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: check every output beat, then stall for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                check_alarm_beat();
                recv_wait = draw_gap(recv_burst);
            end
            if (long_hold_left != 0) begin
                out_if.ready <= 1'b0;
            end else if (recv_wait != 0) begin
                out_if.ready <= 1'b0;
                recv_wait--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Long hold-off: once armed, keep the receiver stalled so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_hold_left <= 0;
            hold_spent     <= 1'b0;
        end else if (hold_request && !hold_spent) begin
            long_hold_left <= LONG_HOLD_CYCLES;
            hold_spent     <= 1'b1;
        end else if (long_hold_left != 0) begin
            long_hold_left <= long_hold_left - 1;
        end
    end

    function automatic void push_beat(logic [OP_BITS-1:0] op, logic [TIME_BITS-1:0] stamp,
                                      logic signed [FEATURE_BITS-1:0] feature);
        sample_beat_t beat;
        beat.op       = op;
        beat.stamp    = stamp;
        beat.feature  = feature;
        beats_to_send = {beats_to_send, beat};
    endfunction

    function automatic logic signed [FEATURE_BITS-1:0] clamp_feature(int value);
        if (value > FEATURE_MAX)
            value = FEATURE_MAX;
        if (value < FEATURE_MIN)
            value = FEATURE_MIN;
        return FEATURE_BITS'(value);
    endfunction

    function automatic int jitter(int unsigned spread);
        return int'($urandom_range(0, 2 * spread)) - int'(spread);
    endfunction

    // One well-formed run: clear, load a rising reference track, then test samples
    // that walk along and past it with features near the reference level.
    function automatic void queue_episode(int unsigned n_refs, int unsigned n_tests,
                                          int unsigned spread);
        int                   level;
        logic [TIME_BITS-1:0] stamp;
        logic [TIME_BITS-1:0] probe;
        level = jitter(30000);
        stamp = $urandom_range(0, 32'hF000_0000);
        probe = stamp - $urandom_range(0, 20);
        push_beat(OP_CLEAR, $urandom, FEATURE_BITS'($urandom));
        for (int unsigned n = 0; n < n_refs; n++) begin
            stamp += $urandom_range(1, 40);
            push_beat(OP_LOAD, stamp, clamp_feature(level + jitter(spread)));
        end
        for (int unsigned n = 0; n < n_tests; n++) begin
            probe += $urandom_range(0, 60);
            push_beat(OP_TEST, probe, clamp_feature(level + jitter(spread)));
        end
    endfunction

    // Broken or stray beats with fully random fields.
    function automatic void queue_noise();
        case ($urandom_range(0, 5))
            0: push_beat(OP_UNUSED, $urandom, FEATURE_BITS'($urandom));
            1: push_beat(OP_LOAD, $urandom, FEATURE_BITS'($urandom));
            4: push_beat(OP_CLEAR, $urandom, FEATURE_BITS'($urandom));
            default: push_beat(OP_TEST, $urandom, FEATURE_BITS'($urandom));
        endcase
    endfunction

    // Queue exactly n_items beats; the last episode is trimmed to fit the budget.
    function automatic void queue_random_phase(int unsigned n_items);
        int unsigned queued;
        int unsigned room;
        int unsigned n_refs;
        int unsigned n_tests;
        int unsigned spread;
        queued = 0;
        while (queued < n_items) begin
            room = n_items - queued;
            if (room < 3 || $urandom_range(0, 4) == 0) begin
                queue_noise();
                queued += 1;
            end else begin
                n_refs  = $urandom_range(1, (room - 2 < 12) ? room - 2 : 12);
                n_tests = $urandom_range(1, (room - 1 - n_refs < 36) ?
                                            room - 1 - n_refs : 36);
                case ($urandom_range(0, 4))
                    0: spread = 0;
                    1: spread = 40;
                    2: spread = 400;
                    3: spread = 4000;
                    default: spread = 40000;
                endcase
                queue_episode(n_refs, n_tests, spread);
                queued += 1 + n_refs + n_tests;
            end
        end
    endfunction

    // Wait until every queued beat went in and every alarm beat came out, then
    // let a silent test finish before touching the registers.
    task automatic wait_for_idle();
        while (beats_to_send.size() != 0 || in_if.valid || alarm_beats_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_reg index, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= index;
        cfg_if.wdata     <= data;
        do
            @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready));
        case (index)
            CFG_WINDOW_LENGTH: window_length_reg = data[WL_BITS-1:0];
            CFG_THRESHOLD: threshold_reg = data[TH_BITS-1:0];
            default: begin
            end
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        in_if.valid          = 1'b0;
        in_if.operation      = OP_CLEAR;
        in_if.timestamp      = '0;
        in_if.feature_value  = '0;
        out_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.reg_index     = CFG_WINDOW_LENGTH;
        cfg_if.wdata         = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats under the reset register values (length 32, threshold 100).
        push_beat(OP_TEST, 32'h0000_1234, 16'sd5);          // empty table: dropped
        push_beat(OP_UNUSED, 32'hFFFF_FFFF, -16'sd1);       // unused code: dropped
        push_beat(OP_LOAD, 32'd100, 16'sd0);
        push_beat(OP_LOAD, 32'd200, 16'sh7FFF);
        push_beat(OP_LOAD, 32'd300, 16'sh8000);
        push_beat(OP_LOAD, 32'hFFFF_FFFF, -16'sd1);
        push_beat(OP_TEST, 32'd0, 16'sh8000);               // pointer stays on the first entry
        push_beat(OP_TEST, 32'd150, 16'sd0);                // pointer steps once
        push_beat(OP_TEST, 32'd250, 16'sh7FFF);             // largest possible square
        push_beat(OP_TEST, 32'hFFFF_FFFF, 16'sh7FFF);       // pointer stops on the last entry
        push_beat(OP_UNUSED, 32'd0, 16'sd0);
        push_beat(OP_CLEAR, 32'hFFFF_FFFF, -16'sd1);
        push_beat(OP_LOAD, 32'h8000_0000, 16'sd12345);
        push_beat(OP_TEST, 32'h7FFF_FFFF, 16'sd12345);      // exact match, sum stays zero
        push_beat(OP_TEST, 32'h8000_0001, 16'sd12445);      // below the limit
        push_beat(OP_TEST, 32'd5, 16'sd12945);              // crosses the limit: alarm
        push_beat(OP_CLEAR, 32'd0, 16'sd0);
        push_beat(OP_TEST, 32'd10, 16'sd10);                // table empty after clear

        // Shortest window with a zero limit: any nonzero error raises an alarm.
        wait_for_idle();
        write_register(CFG_WINDOW_LENGTH, 16'd1);
        write_register(CFG_THRESHOLD, 16'd0);
        queue_random_phase(30);

        // Length zero acts as one; upper data bits of the threshold are dropped.
        wait_for_idle();
        write_register(CFG_WINDOW_LENGTH, 16'd0);
        write_register(CFG_THRESHOLD, 16'hFFFF);
        queue_random_phase(30);

        // Saturated length and the top threshold; end with a full-scale run that
        // fills the whole ring and raises the longest alarms.
        wait_for_idle();
        write_register(CFG_WINDOW_LENGTH, 16'd63);
        write_register(CFG_THRESHOLD, 16'h7FFF);
        queue_random_phase(20);
        push_beat(OP_CLEAR, 32'd0, 16'sd0);
        push_beat(OP_LOAD, 32'd1000, 16'sh7FFF);
        for (int unsigned n = 0; n < 33; n++)
            push_beat(OP_TEST, 32'd1000 + n, 16'sh8000);

        // Shrink the window while the ring is full; the first tests must drop
        // the oldest entries before anything else clears the ring.
        wait_for_idle();
        write_register(CFG_WINDOW_LENGTH, 16'd5);
        write_register(CFG_THRESHOLD, 16'd3000);
        for (int unsigned n = 0; n < 3; n++)
            push_beat(OP_TEST, 32'd1040 + n, FEATURE_BITS'($urandom));
        queue_random_phase(40);

        // Main random run; hold off the receiver for a long stretch at its start
        // so alarm beats back up and the block stops taking input.
        wait_for_idle();
        write_register(CFG_WINDOW_LENGTH, 16'd32);
        write_register(CFG_THRESHOLD, 16'd100);
        hold_request <= 1'b1;
        queue_random_phase(70);

        wait_for_idle();
        write_register(CFG_WINDOW_LENGTH, 16'd17);
        write_register(CFG_THRESHOLD, 16'd1000);
        queue_random_phase(40);

        wait_for_idle();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: a lost or stuck beat ends the run here.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
